// File: rtl/hpq_pkg.sv
// Shared constants, codes and elaboration helpers for the heap priority queue.
package hpq_pkg;

    // Default configuration of the queue.
    localparam int ARITY_DEF     = 4;
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int OP_W       = 2;
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 2;

    // Operation codes carried by an input word.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes carried by a result word.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Number of tree levels needed to hold cap keys with the given fan-out.
    function automatic int level_count(input int arity, input int cap);
        int total;
        int size;
        int n;
        int i;
        total = 0;
        size  = 1;
        n     = 0;
        for (i = 0; i < 32; i++)
        begin
            if (total < cap)
            begin
                total = total + size;
                size  = size * arity;
                n     = n + 1;
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/d_ary_heap_priority_queue_unit.sv
// Top level of the heap priority queue: level cells and the sift sequencer.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     op, key
//   result    out        result_valid / result_stall top_key, top_valid, count, status
//   config    in         cfg_wr_en                   cfg_wr_data (max_first)
//
// One word is worked on at a time, through a read-compare loop over the level cells.
// Clear, refused, unused and last-key pops go straight to the result; a push fetches and
// compares one parent per level climbed, until the key settles or reaches the root; other
// pops fetch the old last key, then one children row per level, until it settles or ends in a leaf.
// Reset clears the count and the order bit; the level memories are not cleared.
// A held result does not block intake; only the next result waits for the output register.
module d_ary_heap_priority_queue_unit #(
    parameter int ARITY     = hpq_pkg::ARITY_DEF,
    parameter int CAPACITY  = hpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [hpq_pkg::OP_W-1:0]         op,
    input  logic [hpq_pkg::KEY_PORT_W-1:0]   key,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [hpq_pkg::KEY_PORT_W-1:0]   top_key,
    output logic                             top_valid,
    output logic [$clog2(CAPACITY+1)-1:0]    count,
    output logic [hpq_pkg::STATUS_W-1:0]     status
);
    import hpq_pkg::*;

    localparam int DB     = $clog2(ARITY);
    localparam int NP     = 1 << DB;
    localparam int LEVELS = level_count(ARITY, CAPACITY);
    localparam int NDIG   = LEVELS - 1;
    localparam int POS_W  = NDIG * DB;
    localparam int LW     = $clog2(LEVELS + 1);
    localparam int LI     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SW     = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_ISSUE,
        S_UP_CMP,
        S_POP_ISSUE,
        S_POP_LOAD,
        S_DN_ISSUE,
        S_DN_CMP,
        S_DONE
    } state_t;

    // True when key a belongs strictly nearer the root than key b.
    function automatic logic ranks_above(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                         input logic mf);
        return mf ? (a > b) : (a < b);
    endfunction

    state_t               state_reg, state_next;
    logic                 max_first_reg, max_first_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [LW-1:0]        nxt_lvl_reg, nxt_lvl_next;
    logic [POS_W-1:0]     nxt_pos_reg, nxt_pos_next;
    logic [LW-1:0]        cur_lvl_reg, cur_lvl_next;
    logic [POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [SW-1:0]        val_reg, val_next;
    logic [SW-1:0]        top_reg, top_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ARITY-1:0]     cmask_reg, cmask_next;
    logic [LI-1:0]        rd_lvl_reg, rd_lvl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KEY_PORT_W-1:0] out_key_reg, out_key_next;
    logic                 out_tv_reg, out_tv_next;
    logic [CW-1:0]        out_count_reg, out_count_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // Level cell access requests.
    logic                 rd_req;
    logic [LW-1:0]        rd_lvl_c;
    logic [POS_W-1:0]     rd_row_c;
    logic                 wr_req;
    logic [LW-1:0]        wr_lvl_c;
    logic [POS_W-1:0]     wr_pos_c;
    logic [POS_W-1:0]     wr_row_c;
    logic [SW-1:0]        wr_data_c;

    logic [ARITY-1:0][SW-1:0] rd_rows [LEVELS];
    logic [ARITY-1:0][SW-1:0] sel_row;

    // Slot arithmetic on the next free node, digits in base ARITY.
    logic [LW-1:0]        adv_lvl, ret_lvl;
    logic [POS_W-1:0]     adv_pos, ret_pos;
    logic [LW-1:0]        child_lvl;
    logic [ARITY-1:0]     child_mask;
    logic [POS_W-1:0]     par_pos;

    // Child selection tree.
    logic                 t_ok  [2*NP];
    logic [SW-1:0]        t_val [2*NP];
    logic [DB-1:0]        t_idx [2*NP];

    assign wr_row_c = wr_pos_c >> DB;
    assign sel_row  = rd_rows[rd_lvl_reg];
    assign par_pos  = cur_pos_reg >> DB;

    // Row of level cells.
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        localparam int RW = (l < 2) ? 1 : (l - 1) * DB;

        hpq_level #(
            .ARITY  (ARITY),
            .DATA_W (SW),
            .ROW_W  (RW)
        ) u_level (
            .clk     (clk),
            .rd_en   (rd_req && (rd_lvl_c == LW'(l))),
            .rd_row  (rd_row_c[RW-1:0]),
            .wr_en   (wr_req && (wr_lvl_c == LW'(l))),
            .wr_row  (wr_row_c[RW-1:0]),
            .wr_lane (wr_pos_c[DB-1:0]),
            .wr_data (wr_data_c),
            .rd_data (rd_rows[l])
        );
    end

    // Next free slot after a push.
    always_comb
    begin
        logic          carry;
        logic [DB-1:0] dig;
        carry   = 1'b1;
        adv_pos = '0;
        for (int k = 0; k < NDIG; k++)
        begin
            dig = nxt_pos_reg[k*DB +: DB];
            if (LW'(k) < nxt_lvl_reg)
            begin
                if (carry)
                begin
                    adv_pos[k*DB +: DB] = (dig == DB'(ARITY - 1)) ? '0 : dig + DB'(1);
                end
                else
                begin
                    adv_pos[k*DB +: DB] = dig;
                end
                carry = carry && (dig == DB'(ARITY - 1));
            end
        end
        if (carry)
        begin
            adv_lvl = nxt_lvl_reg + LW'(1);
            adv_pos = '0;
        end
        else
        begin
            adv_lvl = nxt_lvl_reg;
        end
    end

    // Last occupied slot, which becomes the next free slot after a pop.
    always_comb
    begin
        logic          borrow;
        logic [DB-1:0] dig;
        borrow  = 1'b1;
        ret_pos = '0;
        for (int k = 0; k < NDIG; k++)
        begin
            dig = nxt_pos_reg[k*DB +: DB];
            if (LW'(k) < nxt_lvl_reg)
            begin
                if (borrow)
                begin
                    ret_pos[k*DB +: DB] = (dig == '0) ? DB'(ARITY - 1) : dig - DB'(1);
                end
                else
                begin
                    ret_pos[k*DB +: DB] = dig;
                end
                borrow = borrow && (dig == '0);
            end
        end
        if (borrow)
        begin
            ret_lvl = nxt_lvl_reg - LW'(1);
            for (int k = 0; k < NDIG; k++)
            begin
                ret_pos[k*DB +: DB] = (LW'(k + 1) < nxt_lvl_reg) ? DB'(ARITY - 1) : '0;
            end
        end
        else
        begin
            ret_lvl = nxt_lvl_reg;
        end
    end

    // Which children of the current node are occupied.
    always_comb
    begin
        logic [POS_W-1:0] cpos;
        child_lvl = cur_lvl_reg + LW'(1);
        for (int k = 0; k < ARITY; k++)
        begin
            cpos = POS_W'(cur_pos_reg << DB) | POS_W'(k);
            child_mask[k] = (child_lvl < nxt_lvl_reg) ||
                            ((child_lvl == nxt_lvl_reg) && (cpos < nxt_pos_reg));
        end
    end

    // Best of the fetched children; ties keep the lower-numbered child.
    always_comb
    begin
        for (int j = 0; j < 2 * NP; j++)
        begin
            t_ok[j]  = 1'b0;
            t_val[j] = '0;
            t_idx[j] = '0;
        end
        for (int j = 0; j < ARITY; j++)
        begin
            t_ok[NP+j]  = cmask_reg[j];
            t_val[NP+j] = sel_row[j];
            t_idx[NP+j] = DB'(j);
        end
        for (int i = NP - 1; i >= 1; i--)
        begin
            if (!t_ok[2*i] ||
                (t_ok[2*i+1] && ranks_above(t_val[2*i+1], t_val[2*i], max_first_reg)))
            begin
                t_ok[i]  = t_ok[2*i+1];
                t_val[i] = t_val[2*i+1];
                t_idx[i] = t_idx[2*i+1];
            end
            else
            begin
                t_ok[i]  = t_ok[2*i];
                t_val[i] = t_val[2*i];
                t_idx[i] = t_idx[2*i];
            end
        end
    end

    // Sift sequencer.
    always_comb
    begin
        state_next      = state_reg;
        max_first_next  = max_first_reg;
        count_next      = count_reg;
        nxt_lvl_next    = nxt_lvl_reg;
        nxt_pos_next    = nxt_pos_reg;
        cur_lvl_next    = cur_lvl_reg;
        cur_pos_next    = cur_pos_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        cmask_next      = cmask_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_key_next    = out_key_reg;
        out_tv_next     = out_tv_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        rd_req          = 1'b0;
        rd_lvl_c        = '0;
        rd_row_c        = '0;
        wr_req          = 1'b0;
        wr_lvl_c        = '0;
        wr_pos_c        = '0;
        wr_data_c       = '0;

        if (cfg_wr_en)
        begin
            max_first_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (op)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next   = count_reg + CW'(1);
                                nxt_lvl_next = adv_lvl;
                                nxt_pos_next = adv_pos;
                                cur_lvl_next = nxt_lvl_reg;
                                cur_pos_next = nxt_pos_reg;
                                val_next     = key[SW-1:0];
                                state_next   = S_UP_ISSUE;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next   = count_reg - CW'(1);
                                nxt_lvl_next = ret_lvl;
                                nxt_pos_next = ret_pos;
                                if (count_reg != CW'(1))
                                begin
                                    state_next = S_POP_ISSUE;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            nxt_lvl_next = '0;
                            nxt_pos_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Fetch the parent, or settle the key at the root.
            S_UP_ISSUE:
            begin
                if (cur_lvl_reg == '0)
                begin
                    wr_req     = 1'b1;
                    wr_lvl_c   = '0;
                    wr_pos_c   = '0;
                    wr_data_c  = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_req     = 1'b1;
                    rd_lvl_c   = cur_lvl_reg - LW'(1);
                    rd_row_c   = par_pos >> DB;
                    state_next = S_UP_CMP;
                end
            end

            // Move the parent down one level, or settle the key here.
            S_UP_CMP:
            begin
                wr_req   = 1'b1;
                wr_lvl_c = cur_lvl_reg;
                wr_pos_c = cur_pos_reg;
                if (ranks_above(val_reg, sel_row[par_pos[DB-1:0]], max_first_reg))
                begin
                    wr_data_c    = sel_row[par_pos[DB-1:0]];
                    cur_lvl_next = cur_lvl_reg - LW'(1);
                    cur_pos_next = par_pos;
                    state_next   = S_UP_ISSUE;
                end
                else
                begin
                    wr_data_c  = val_reg;
                    state_next = S_DONE;
                end
            end

            // Fetch the old last key, whose slot is now the next free one.
            S_POP_ISSUE:
            begin
                rd_req     = 1'b1;
                rd_lvl_c   = nxt_lvl_reg;
                rd_row_c   = nxt_pos_reg >> DB;
                state_next = S_POP_LOAD;
            end

            S_POP_LOAD:
            begin
                val_next     = sel_row[nxt_pos_reg[DB-1:0]];
                cur_lvl_next = '0;
                cur_pos_next = '0;
                state_next   = S_DN_ISSUE;
            end

            // Fetch the children row, or settle the key in a leaf.
            S_DN_ISSUE:
            begin
                if (child_mask == '0)
                begin
                    wr_req     = 1'b1;
                    wr_lvl_c   = cur_lvl_reg;
                    wr_pos_c   = cur_pos_reg;
                    wr_data_c  = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_req     = 1'b1;
                    rd_lvl_c   = child_lvl;
                    rd_row_c   = cur_pos_reg;
                    cmask_next = child_mask;
                    state_next = S_DN_CMP;
                end
            end

            // Lift the best child one level, or settle the key here.
            S_DN_CMP:
            begin
                wr_req   = 1'b1;
                wr_lvl_c = cur_lvl_reg;
                wr_pos_c = cur_pos_reg;
                if (ranks_above(t_val[1], val_reg, max_first_reg))
                begin
                    wr_data_c    = t_val[1];
                    cur_lvl_next = child_lvl;
                    cur_pos_next = POS_W'(cur_pos_reg << DB) | POS_W'(t_idx[1]);
                    state_next   = S_DN_ISSUE;
                end
                else
                begin
                    wr_data_c  = val_reg;
                    state_next = S_DONE;
                end
            end

            // Hand the result word to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_tv_next     = (count_reg != '0);
                    out_key_next    = (count_reg != '0) ? KEY_PORT_W'(top_reg) : '0;
                    out_count_next  = count_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Root copy follows every write to the top level.
    assign top_next    = (wr_req && (wr_lvl_c == '0)) ? wr_data_c : top_reg;
    assign rd_lvl_next = rd_req ? rd_lvl_c[LI-1:0] : rd_lvl_reg;

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_first_reg  <= 1'b0;
            count_reg      <= '0;
            nxt_lvl_reg    <= '0;
            nxt_pos_reg    <= '0;
            cur_lvl_reg    <= '0;
            cur_pos_reg    <= '0;
            val_reg        <= '0;
            top_reg        <= '0;
            status_reg     <= ST_OK;
            cmask_reg      <= '0;
            rd_lvl_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_key_reg    <= '0;
            out_tv_reg     <= 1'b0;
            out_count_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            max_first_reg  <= max_first_next;
            count_reg      <= count_next;
            nxt_lvl_reg    <= nxt_lvl_next;
            nxt_pos_reg    <= nxt_pos_next;
            cur_lvl_reg    <= cur_lvl_next;
            cur_pos_reg    <= cur_pos_next;
            val_reg        <= val_next;
            top_reg        <= top_next;
            status_reg     <= status_next;
            cmask_reg      <= cmask_next;
            rd_lvl_reg     <= rd_lvl_next;
            out_valid_reg  <= out_valid_next;
            out_key_reg    <= out_key_next;
            out_tv_reg     <= out_tv_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign top_key      = out_key_reg;
    assign top_valid    = out_tv_reg;
    assign count        = out_count_reg;
    assign status       = out_status_reg;

endmodule

// File: rtl/hpq_level.sv
// One tree level of the heap: key storage organized as rows of sibling groups.
module hpq_level #(
    parameter int ARITY  = hpq_pkg::ARITY_DEF,
    parameter int DATA_W = hpq_pkg::KEY_WIDTH_DEF,
    parameter int ROW_W  = 1
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [ROW_W-1:0]                   rd_row,
    input  logic                               wr_en,
    input  logic [ROW_W-1:0]                   wr_row,
    input  logic [$clog2(ARITY)-1:0]           wr_lane,
    input  logic [DATA_W-1:0]                  wr_data,
    output logic [ARITY-1:0][DATA_W-1:0]       rd_data
);
    import hpq_pkg::*;

    // Each row holds all children of one node of the level above.
    logic [ARITY-1:0][DATA_W-1:0] row_mem [2**ROW_W];
    logic [ARITY-1:0][DATA_W-1:0] rd_data_reg;

    // Single-lane write, whole-row registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_row][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/d_ary_heap_priority_queue_unit_tb.sv
// Self-checking testbench for the heap priority queue unit with a built-in heap predictor.
`timescale 1ns / 100ps

module d_ary_heap_priority_queue_unit_tb;

    import hpq_pkg::*;

    localparam int ARITY    = ARITY_DEF;
    localparam int CAPACITY = CAPACITY_DEF;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // The one op code the block treats as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass after the last result before touching the register.
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold-off used to back the block up.
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE  = 168;
    localparam int PHASE_COUNT      = 8;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [KEY_PORT_W-1:0] key;
    } queue_cmd_t;

    typedef struct packed {
        logic [KEY_PORT_W-1:0] top_key;
        logic                  top_valid;
        logic [CNT_W-1:0]      count;
        logic [STATUS_W-1:0]   status;
    } queue_report_t;

    typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_kind_t;

    // Block ports.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic                  cfg_wr_data  = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    logic [OP_W-1:0]       op           = OP_PUSH;
    logic [KEY_PORT_W-1:0] key          = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [KEY_PORT_W-1:0] top_key;
    logic                  top_valid;
    logic [CNT_W-1:0]      count;
    logic [STATUS_W-1:0]   status;

    // Predictor state: 1-based heap, fill level and key order.
    logic [KEY_PORT_W-1:0] heap_keys [1:CAPACITY];
    int                    heap_fill  = 0;
    logic                  heap_order = 1'b0;

    queue_cmd_t    cmd_backlog [$];
    queue_report_t report_backlog [$];

    int   mismatch_count = 0;
    logic no_idle        = 1'b0;
    int   long_hold_req  = 0;

    d_ary_heap_priority_queue_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .key          (key),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .top_key      (top_key),
        .top_valid    (top_valid),
        .count        (count),
        .status       (status)
    );

    always #10 clk = ~clk;

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // True when key a belongs strictly nearer the root than key b.
    function automatic logic ranks_above(input logic [KEY_PORT_W-1:0] a,
                                         input logic [KEY_PORT_W-1:0] b);
        return heap_order ? (a > b) : (a < b);
    endfunction

    // Apply one word to the predicted heap and return the result it should produce.
    function automatic queue_report_t heap_apply(input logic [OP_W-1:0] cmd,
                                                 input logic [KEY_PORT_W-1:0] k);
        queue_report_t         r;
        int                    n;
        int                    up;
        int                    first;
        int                    best;
        int                    c;
        logic [KEY_PORT_W-1:0] v;
        logic [KEY_PORT_W-1:0] bv;
        logic                  done;
        r.status = ST_OK;
        case (cmd)
            OP_PUSH:
            begin
                if (heap_fill >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Sift the new key up; equal keys never pass each other.
                    heap_fill++;
                    n    = heap_fill;
                    v    = k;
                    done = 1'b0;
                    while (n > 1 && !done)
                    begin
                        up = (n - 2) / ARITY + 1;
                        if (ranks_above(v, heap_keys[up]))
                        begin
                            heap_keys[n] = heap_keys[up];
                            n = up;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    heap_keys[n] = v;
                end
            end
            OP_POP:
            begin
                if (heap_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    heap_keys[1] = heap_keys[heap_fill];
                    heap_fill--;
                    if (heap_fill > 0)
                    begin
                        // Sift the moved key down, taking the lowest-numbered best child.
                        n    = 1;
                        v    = heap_keys[1];
                        done = 1'b0;
                        while (!done)
                        begin
                            first = ARITY * (n - 1) + 2;
                            if (first > heap_fill)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                best = 0;
                                bv   = '0;
                                for (c = first; c < first + ARITY && c <= heap_fill; c++)
                                begin
                                    if (best == 0 || ranks_above(heap_keys[c], bv))
                                    begin
                                        best = c;
                                        bv   = heap_keys[c];
                                    end
                                end
                                if (ranks_above(bv, v))
                                begin
                                    heap_keys[n] = bv;
                                    n = best;
                                end
                                else
                                begin
                                    done = 1'b1;
                                end
                            end
                        end
                        heap_keys[n] = v;
                    end
                end
            end
            OP_CLEAR:
            begin
                heap_fill = 0;
            end
            default:
            begin
            end
        endcase
        r.top_valid = (heap_fill > 0);
        r.top_key   = (heap_fill > 0) ? heap_keys[1] : '0;
        r.count     = CNT_W'(heap_fill);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    // Keys: full-range values, tight ranges that force ties, and the extremes.
    function automatic logic [KEY_PORT_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom;
        end
        else if (r < 80)
        begin
            return $urandom_range(0, 7);
        end
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    endfunction

    // Random word whose op mix depends on what the phase is meant to reach.
    function automatic queue_cmd_t pick_cmd(input phase_kind_t kind);
        queue_cmd_t c;
        int         r;
        int         push_pct;
        int         pop_pct;
        r = $urandom_range(0, 99);
        case (kind)
            FILL_PHASE:
            begin
                push_pct = 90;
                pop_pct  = 7;
            end
            DRAIN_PHASE:
            begin
                push_pct = 27;
                pop_pct  = 70;
            end
            default:
            begin
                push_pct = 52;
                pop_pct  = 42;
            end
        endcase
        if (r < push_pct)
        begin
            c.op = OP_PUSH;
        end
        else if (r < push_pct + pop_pct)
        begin
            c.op = OP_POP;
        end
        else if (r < push_pct + pop_pct + 2)
        begin
            c.op = OP_CLEAR;
        end
        else
        begin
            c.op = OP_UNUSED;
        end
        c.key = (c.op == OP_PUSH) ? pick_key() : KEY_PORT_W'($urandom);
        return c;
    endfunction

    task automatic add_cmd(input logic [OP_W-1:0] o, input logic [KEY_PORT_W-1:0] k);
        queue_cmd_t c;
        c.op  = o;
        c.key = k;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Write the order register while the block is idle.
    task automatic write_order(input logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        heap_order = v;
        @(negedge clk);
    endtask

    // Hold off new words until every result is in, then let the block settle.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || item_valid || report_backlog.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: presents words from the backlog, with random gaps between them.
    always @(posedge clk)
    begin : sender
        queue_cmd_t next_cmd;
        int         send_gap;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                report_backlog = {report_backlog, heap_apply(op, key)};
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0 && !no_idle)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    op         <= next_cmd.op;
                    key        <= next_cmd.key;
                    item_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result word and drives random stalls.
    always @(posedge clk)
    begin : receiver
        queue_report_t want;
        int            stall_left;
        int            hold_left;
        int            hold_seen;
        logic          stall_next;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_seen  = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (report_backlog.size() == 0)
                begin
                    report_mismatch("result word with nothing expected");
                end
                else
                begin
                    want = report_backlog.pop_front();
                    if (top_key !== want.top_key)
                    begin
                        report_mismatch($sformatf("top_key got %h want %h",
                                                  top_key, want.top_key));
                    end
                    if (top_valid !== want.top_valid)
                    begin
                        report_mismatch($sformatf("top_valid got %b want %b",
                                                  top_valid, want.top_valid));
                    end
                    if (count !== want.count)
                    begin
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  count, want.count));
                    end
                    if (status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    end
                end
            end
            if (long_hold_req != hold_seen)
            begin
                hold_seen = long_hold_req;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (no_idle)
            begin
                stall_left = 0;
                stall_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
                stall_next = (stall_left > 0);
            end
            result_stall <= stall_next;
        end
    end

    // Stimulus: directed cases, then random phases under both key orders.
    initial
    begin : stimulus
        phase_kind_t kind;
        int          p;
        int          i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest key first: empty cases, extremes, ties and the unused op.
        write_order(1'b0);
        add_cmd(OP_POP,    32'h0000_0000);
        add_cmd(OP_CLEAR,  32'hFFFF_FFFF);
        add_cmd(OP_UNUSED, 32'hFFFF_FFFF);
        add_cmd(OP_PUSH,   32'hFFFF_FFFF);
        add_cmd(OP_PUSH,   32'h0000_0000);
        add_cmd(OP_PUSH,   32'h0000_0007);
        add_cmd(OP_PUSH,   32'h0000_0007);
        add_cmd(OP_PUSH,   32'h8000_0000);
        add_cmd(OP_PUSH,   32'h0000_0000);
        add_cmd(OP_POP,    32'h5555_5555);
        add_cmd(OP_POP,    32'hAAAA_AAAA);
        add_cmd(OP_POP,    32'h0000_0000);
        add_cmd(OP_UNUSED, 32'h0000_0000);
        add_cmd(OP_CLEAR,  32'h0000_0000);
        add_cmd(OP_POP,    32'h0000_0000);
        add_cmd(OP_PUSH,   32'h0000_0003);
        add_cmd(OP_PUSH,   32'h0000_0001);
        add_cmd(OP_PUSH,   32'h0000_0002);
        wait_drained();

        // Flip to largest first while keys are still held.
        write_order(1'b1);
        add_cmd(OP_PUSH, 32'h0000_0000);
        add_cmd(OP_PUSH, 32'hFFFF_FFFF);
        add_cmd(OP_POP,  32'h0000_0000);
        add_cmd(OP_POP,  32'h0000_0000);
        add_cmd(OP_POP,  32'h0000_0000);
        add_cmd(OP_POP,  32'h0000_0000);
        add_cmd(OP_POP,  32'h0000_0000);
        wait_drained();

        // Random phases: mixed traffic, filling past full, and draining past empty.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
            begin
                write_order(1'b0);
            end
            else if (p == 1)
            begin
                write_order(1'b1);
            end
            else
            begin
                write_order(1'($urandom_range(0, 1)));
            end
            case (p % 3)
                1:       kind = FILL_PHASE;
                2:       kind = DRAIN_PHASE;
                default: kind = MIX_PHASE;
            endcase
            no_idle = (p == 3);
            if (p == 1)
            begin
                long_hold_req++;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                cmd_backlog = {cmd_backlog, pick_cmd(kind)};
            end
            wait_drained();
            no_idle = 1'b0;
        end

        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: d_ary_heap_priority_queue_unit.f
rtl/hpq_pkg.sv
rtl/hpq_level.sv
rtl/d_ary_heap_priority_queue_unit.sv
tb/d_ary_heap_priority_queue_unit_tb.sv
